// File: rtl/wca_pkg.sv
// Package for the weighted centroid accumulator.
// Transaction payload types, opcodes, controller commands and FSM states.
// No dependencies.
`default_nettype none

package wca_pkg;

   // Opcodes carried in the request
   localparam logic [1:0] OP_CLEAR = 2'd0;
   localparam logic [1:0] OP_ACCUM = 2'd1;
   localparam logic [1:0] OP_READ  = 2'd2;
   localparam logic [1:0] OP_SPARE = 2'd3;

   // Quotient bits produced by the divider lanes
   localparam int QBITS = 16;
   localparam int CHANS = 4;
   localparam int LANES = CHANS + 1;
   localparam int POP_BITS = 36;

   typedef struct packed {
      logic [1:0]  opcode;
      logic [7:0]  entry;
      logic [15:0] chan_alpha;
      logic [15:0] chan_red;
      logic [15:0] chan_green;
      logic [15:0] chan_blue;
      logic [15:0] weight;
      logic [15:0] match_error;
   } req_type;

   typedef struct packed {
      logic                status;
      logic [15:0]         avg_alpha;
      logic [15:0]         avg_red;
      logic [15:0]         avg_green;
      logic [15:0]         avg_blue;
      logic [POP_BITS-1:0] popularity;
      logic                kept_previous;
      logic [15:0]         mean_error;
   } rsp_type;

   // Commands from controller to datapath
   typedef struct packed {
      logic capture;
      logic update;
      logic setup;
      logic sat_check;
      logic div_step;
      logic load_rsp;
   } cmd_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_FETCH,
      ST_UPDATE,
      ST_SETUP,
      ST_SATCHK,
      ST_DIVIDE,
      ST_FINISH
   } state_type;

endpackage

`default_nettype wire

// File: rtl/wca_ctrl.sv
// Controller for the weighted centroid accumulator.
// Sequences fetch, update, divide and response load; depends on wca_pkg.
`default_nettype none

module wca_ctrl
   import wca_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_ready,
   output logic         rsp_valid,
   input  wire logic    rsp_ready,
   output cmd_type      cmd
);

   localparam int CNT_BITS = $clog2(QBITS);

   state_type               state_ff, state_in;
   logic [CNT_BITS-1:0]     cnt_ff, cnt_in;
   logic                    rsp_valid_ff, rsp_valid_in;

   // State and step counter registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Next state and commands
   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      cmd          = '0;
      req_ready    = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = ST_FETCH;
            end
         end
         ST_FETCH: begin
            state_in = ST_UPDATE;
         end
         ST_UPDATE: begin
            cmd.update = 1'b1;
            state_in   = ST_SETUP;
         end
         ST_SETUP: begin
            cmd.setup = 1'b1;
            state_in  = ST_SATCHK;
         end
         ST_SATCHK: begin
            cmd.sat_check = 1'b1;
            cnt_in        = '0;
            state_in      = ST_DIVIDE;
         end
         ST_DIVIDE: begin
            cmd.div_step = 1'b1;
            cnt_in       = cnt_ff + CNT_BITS'(1);
            if (cnt_ff == CNT_BITS'(QBITS - 1)) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            // Output register must be free or draining this cycle
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.load_rsp = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

`default_nettype wire

// File: rtl/wca_dpath.sv
// Datapath for the weighted centroid accumulator.
// Entry memory, running totals, five restoring divider lanes, output register.
// Depends on wca_pkg.
`default_nettype none

module wca_dpath
   import wca_pkg::*;
#(
   parameter int MAX_ENTRIES       = 256,
   parameter int SAMPLE_COUNT_BITS = 20
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire cmd_type    cmd,
   input  wire req_type    req_data,
   input  wire logic       csr_we,
   input  wire logic [8:0] csr_data,
   output rsp_type         rsp_data
);

   localparam int SW = 32 + SAMPLE_COUNT_BITS;
   localparam int WW = 16 + SAMPLE_COUNT_BITS;
   localparam int AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;

   typedef struct packed {
      logic [CHANS-1:0][SW-1:0] sum;
      logic [WW-1:0]            ws;
   } ent_type;

   function automatic logic [SW-1:0] sat_sum(input logic [SW-1:0] a, input logic [31:0] b);
      logic [SW:0] s;
      s = {1'b0, a} + (SW+1)'(b);
      return s[SW] ? '1 : s[SW-1:0];
   endfunction

   function automatic logic [WW-1:0] sat_w(input logic [WW-1:0] a, input logic [15:0] b);
      logic [WW:0] s;
      s = {1'b0, a} + (WW+1)'(b);
      return s[WW] ? '1 : s[WW-1:0];
   endfunction

   // Configuration register
   logic [8:0] color_count_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         color_count_ff <= 9'd256;
      end else if (csr_we) begin
         color_count_ff <= csr_data;
      end
   end

   // Captured request
   req_type item_ff;
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         item_ff <= req_data;
      end
   end

   logic [AW-1:0] addr;
   logic          entry_ok;
   assign addr     = AW'(item_ff.entry);
   assign entry_ok = ({1'b0, item_ff.entry} < color_count_ff) &&
                     (32'(item_ff.entry) < MAX_ENTRIES);

   // Entry memory with registered read
   ent_type mem [MAX_ENTRIES];
   ent_type rd_ff;
   ent_type wr_in;
   logic    wr_en;
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[addr] <= wr_in;
      end
      rd_ff <= mem[addr];
   end

   // Per-entry valid bits stand in for clearing the memory
   logic [MAX_ENTRIES-1:0] vld_ff;
   logic                   vld_rd_ff;

   // Products registered ahead of the accumulate
   logic [CHANS-1:0][31:0] prod_ff;
   logic [31:0]            perr_ff;
   always_ff @(posedge clock) begin
      prod_ff[0] <= 32'(item_ff.weight) * 32'(item_ff.chan_alpha);
      prod_ff[1] <= 32'(item_ff.weight) * 32'(item_ff.chan_red);
      prod_ff[2] <= 32'(item_ff.weight) * 32'(item_ff.chan_green);
      prod_ff[3] <= 32'(item_ff.weight) * 32'(item_ff.chan_blue);
      perr_ff    <= 32'(item_ff.weight) * 32'(item_ff.match_error);
      vld_rd_ff  <= vld_ff[addr];
   end

   // Read-modify-write of the entry
   ent_type cur;
   logic    do_accum;
   logic    do_clear;
   assign cur      = vld_rd_ff ? rd_ff : '0;
   assign do_accum = cmd.update && (item_ff.opcode == OP_ACCUM) && entry_ok;
   assign do_clear = cmd.update && (item_ff.opcode == OP_CLEAR);
   assign wr_en    = do_accum;

   always_comb begin
      for (int c = 0; c < CHANS; c++) begin
         wr_in.sum[c] = sat_sum(cur.sum[c], prod_ff[c]);
      end
      wr_in.ws = sat_w(cur.ws, item_ff.weight);
   end

   logic [SW-1:0] tot_err_ff, tot_err_in;
   logic [WW-1:0] tot_w_ff, tot_w_in;
   ent_type       ent_ff;
   logic [WW-1:0] pop_ff;

   always_comb begin
      tot_err_in = tot_err_ff;
      tot_w_in   = tot_w_ff;
      if (do_clear) begin
         tot_err_in = '0;
         tot_w_in   = '0;
      end else if (do_accum) begin
         tot_err_in = sat_sum(tot_err_ff, perr_ff);
         tot_w_in   = sat_w(tot_w_ff, item_ff.weight);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff     <= '0;
         tot_err_ff <= '0;
         tot_w_ff   <= '0;
      end else begin
         tot_err_ff <= tot_err_in;
         tot_w_ff   <= tot_w_in;
         if (do_clear) begin
            vld_ff <= '0;
         end else if (do_accum) begin
            vld_ff[addr] <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.update) begin
         ent_ff <= cur;
         if (do_accum) begin
            pop_ff <= wr_in.ws;
         end else if ((item_ff.opcode == OP_READ) && entry_ok) begin
            pop_ff <= cur.ws;
         end else begin
            pop_ff <= '0;
         end
      end
   end

   // Divider lanes: four channel means and the mean error
   logic [LANES-1:0][SW:0]       rem_ff;
   logic [LANES-1:0][SW:0]       dsh_ff;
   logic [LANES-1:0][WW-1:0]     den_ff;
   logic [LANES-1:0]             sat_ff;
   logic [LANES-1:0][QBITS-1:0]  q_ff;
   logic [LANES-1:0][SW-1:0]     num_l;
   logic [LANES-1:0][WW-1:0]     den_l;
   logic [LANES-1:0][15:0]       res_l;

   always_comb begin
      for (int l = 0; l < CHANS; l++) begin
         num_l[l] = ent_ff.sum[l];
         den_l[l] = ent_ff.ws;
      end
      num_l[CHANS] = tot_err_ff;
      den_l[CHANS] = tot_w_ff;
   end

   always_ff @(posedge clock) begin
      for (int l = 0; l < LANES; l++) begin
         if (cmd.setup) begin
            // Rounding half up: divide num + den/2
            rem_ff[l] <= (SW+1)'(num_l[l]) + (SW+1)'(den_l[l] >> 1);
            dsh_ff[l] <= (SW+1)'(den_l[l]) << (QBITS - 1);
            den_ff[l] <= den_l[l];
         end else if (cmd.sat_check) begin
            sat_ff[l] <= rem_ff[l] >= ((SW+1)'(den_ff[l]) << QBITS);
         end else if (cmd.div_step) begin
            if (rem_ff[l] >= dsh_ff[l]) begin
               rem_ff[l] <= rem_ff[l] - dsh_ff[l];
               q_ff[l]   <= {q_ff[l][QBITS-2:0], 1'b1};
            end else begin
               q_ff[l]   <= {q_ff[l][QBITS-2:0], 1'b0};
            end
            dsh_ff[l] <= dsh_ff[l] >> 1;
         end
      end
   end

   always_comb begin
      for (int l = 0; l < LANES; l++) begin
         if (den_ff[l] == '0) begin
            res_l[l] = '0;
         end else if (sat_ff[l]) begin
            res_l[l] = '1;
         end else begin
            res_l[l] = q_ff[l];
         end
      end
   end

   // Response assembly
   rsp_type rsp_in, rsp_ff;
   logic    is_read, is_acc, ws_zero, echo;
   assign is_read = (item_ff.opcode == OP_READ);
   assign is_acc  = (item_ff.opcode == OP_ACCUM);
   assign ws_zero = (ent_ff.ws == '0);
   assign echo    = is_read && (!entry_ok || ws_zero);

   always_comb begin
      rsp_in               = '0;
      rsp_in.status        = (is_read || is_acc) && !entry_ok;
      rsp_in.kept_previous = is_read && entry_ok && ws_zero;
      rsp_in.mean_error    = res_l[CHANS];
      rsp_in.popularity    = (64'(pop_ff) > ((64'd1 << POP_BITS) - 64'd1)) ?
                             '1 : POP_BITS'(pop_ff);
      if (echo) begin
         rsp_in.avg_alpha = item_ff.chan_alpha;
         rsp_in.avg_red   = item_ff.chan_red;
         rsp_in.avg_green = item_ff.chan_green;
         rsp_in.avg_blue  = item_ff.chan_blue;
      end else if (is_read) begin
         rsp_in.avg_alpha = res_l[0];
         rsp_in.avg_red   = res_l[1];
         rsp_in.avg_green = res_l[2];
         rsp_in.avg_blue  = res_l[3];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_rsp) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_data = rsp_ff;

endmodule

`default_nettype wire

// File: rtl/weighted_centroid_accumulator.sv
// Top level of the weighted centroid accumulator.
// Joins wca_ctrl and wca_dpath; depends on wca_pkg.
//
//   channel   direction   payload        handshake
//   req       in          req_type       req_valid / req_ready
//   rsp       out         rsp_type       rsp_valid / rsp_ready
//   csr       in          color_count    csr_valid / csr_ready
//
// Every transaction runs from acceptance to a loaded response through fetch,
// update, divider setup, saturation check, then 16 quotient steps in five
// parallel restoring divider lanes, and one response load. The next request
// is taken in the cycle after the load. The response register lets a new
// request be accepted while the previous response waits; that request
// stalls in its load cycle until the register drains. Synchronous reset
// clears the entry valid bits and totals at once; there is no clearing
// pass. csr writes are always taken.
`default_nettype none

module weighted_centroid_accumulator
   import wca_pkg::*;
#(
   parameter int MAX_ENTRIES       = 256,
   parameter int SAMPLE_COUNT_BITS = 20
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_ready,
   input  wire req_type    req_data,
   output logic            rsp_valid,
   input  wire logic       rsp_ready,
   output rsp_type         rsp_data,
   input  wire logic       csr_valid,
   output logic            csr_ready,
   input  wire logic [8:0] csr_data
);

   cmd_type cmd;

   assign csr_ready = 1'b1;

   wca_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd)
   );

   wca_dpath #(
      .MAX_ENTRIES       (MAX_ENTRIES),
      .SAMPLE_COUNT_BITS (SAMPLE_COUNT_BITS)
   ) u_dpath (
      .clock    (clock),
      .reset    (reset),
      .cmd      (cmd),
      .req_data (req_data),
      .csr_we   (csr_valid && csr_ready),
      .csr_data (csr_data),
      .rsp_data (rsp_data)
   );

endmodule

`default_nettype wire
